@@ rtl/masked_normalized_gradient_3d_top_assert.svh @@
// assertion macros for the masked gradient block checker
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef MASKED_NORMALIZED_GRADIENT_3D_TOP_ASSERT_SVH
`define MASKED_NORMALIZED_GRADIENT_3D_TOP_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define MNG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while in reset
`define MNG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mng_pkg.sv @@
// shared types and constants of the masked gradient block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mng_pkg;

    // volume limits
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int MAX_PLANES = 1024;
    localparam int DIM_MIN    = 3;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int PLANE_W = $clog2(MAX_PLANES);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int MEM_AW  = ADDR_W + 1;
    localparam int MEM_DW  = 17;

    // register widths
    localparam int DIM_X_W    = 11;
    localparam int DIM_Y_W    = 7;
    localparam int DIM_Z_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 3'd4;

    // register reset values
    localparam logic signed [15:0] INNER_RST = 16'sd0;
    localparam logic signed [15:0] OUTER_RST = 16'sd10000;
    localparam logic [DIM_X_W-1:0] DIM_X_RST = 11'd64;
    localparam logic [DIM_Y_W-1:0] DIM_Y_RST = 7'd64;
    localparam logic [DIM_Z_W-1:0] DIM_Z_RST = 7'd64;

    // arithmetic widths
    localparam int QBITS = 15;
    localparam int SQ_W  = 32;
    localparam int SUM_W = 34;
    localparam int QS_W  = SUM_W + QBITS;
    localparam int REM_W = 64;

    // pipeline layout: stage of the top quotient bit and the output stage
    localparam int DIV_FIRST = 5;
    localparam int NSTAGE    = DIV_FIRST + QBITS;

    typedef struct packed {
        logic signed [15:0] potential;
        logic signed [15:0] label;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               inside_res;
        logic               last;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/mng_ram.sv @@
// generic memory, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mng_ram #(
    parameter int AW = 13,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

@@ rtl/mng_udiv.sv @@
// pipelined restoring search for the unit component magnitude
// one quotient bit per stage; uses mng_pkg
`timescale 1ns / 1ps
`default_nettype none

module mng_udiv import mng_pkg::*; (
    input  logic             i_clk,
    input  logic [QBITS-1:0] i_en,
    input  logic [SQ_W-1:0]  i_sq,
    input  logic [SUM_W-1:0] i_sum,
    output logic [QBITS-1:0] o_q
);

    // per stage: remainder d*d*2^30 - q*q*s, running q*s, q and s
    logic [REM_W-1:0] r_rem [QBITS];
    logic [QS_W-1:0]  r_qs  [QBITS];
    logic [QBITS-1:0] r_q   [QBITS];
    logic [SUM_W-1:0] r_sum [QBITS];

    for (genvar k = 0; k < QBITS; k++) begin : g_bit
        logic [REM_W-1:0] w_rem_in;
        logic [QS_W-1:0]  w_qs_in;
        logic [QBITS-1:0] w_q_in;
        logic [SUM_W-1:0] w_sum_in;
        logic [REM_W-1:0] w_delta;
        logic             w_take;
        logic [REM_W-1:0] n_rem;
        logic [QS_W-1:0]  n_qs;
        logic [QBITS-1:0] n_q;

        // top bit starts from the scaled square
        if (k == QBITS - 1) begin : g_head
            assign w_rem_in = REM_W'(i_sq) << (2 * QBITS);
            assign w_qs_in  = '0;
            assign w_q_in   = '0;
            assign w_sum_in = i_sum;
        end else begin : g_body
            assign w_rem_in = r_rem[k+1];
            assign w_qs_in  = r_qs[k+1];
            assign w_q_in   = r_q[k+1];
            assign w_sum_in = r_sum[k+1];
        end

        // (q + 2^k)^2 s - q^2 s = 2^(k+1) q s + 2^(2k) s
        assign w_delta = (REM_W'(w_qs_in) << (k + 1)) + (REM_W'(w_sum_in) << (2 * k));
        assign w_take  = (w_delta <= w_rem_in);
        assign n_rem   = w_take ? (w_rem_in - w_delta) : w_rem_in;
        assign n_qs    = w_take ? (w_qs_in + (QS_W'(w_sum_in) << k)) : w_qs_in;
        assign n_q     = w_q_in | (w_take ? (QBITS'(1) << k) : '0);

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem;
                r_qs[k]  <= n_qs;
                r_q[k]   <= n_q;
                r_sum[k] <= w_sum_in;
            end
        end
    end

    assign o_q = r_q[0];

endmodule

`default_nettype wire

@@ rtl/masked_normalized_gradient_3d_top.sv @@
// Masked unit gradient of a streamed 3-D potential volume.
// Voxels enter in raster order (plane, row, column fastest) on a valid/ready
// channel; each item carries a potential and a tissue label. An item at plane
// p >= 1 yields one result for the voxel one plane behind; items of plane 0
// yield none and the last plane is never emitted.
// Result: central differences on three axes scaled to unit length in Q1.15,
// zero for masked or border voxels, inside_res and last flags.
// Pipeline: a plane memory read with the item registers, then difference,
// square and sum stages, the one-bit-per-stage magnitude search and one
// output register.
// Throughput: one item per clock; every stage has a valid bit and advances
// when it is empty or the stage after it moves, so bubbles close up and the
// block keeps taking items while a finished result waits at the output.
// When the receiver stalls with the pipeline full, o_in_ready falls.
// Reset clears valid bits, the position and the registers (inner 0,
// outer 10000, dims 64), not the plane memories, whose data is used only once
// written. Register writes must go in when idle; the block does not check.
// Uses mng_pkg, mng_ram, mng_udiv.
`timescale 1ns / 1ps
`default_nettype none

module masked_normalized_gradient_3d_top import mng_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_res                  o_out_item
);

    typedef struct packed {
        logic ok;
        logic zero;
        logic last;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } t_side;

    // configuration registers
    logic signed [15:0]  r_inner;
    logic signed [15:0]  r_outer;
    logic [DIM_X_W-1:0]  r_dim_x;
    logic [DIM_Y_W-1:0]  r_dim_y;
    logic [DIM_Z_W-1:0]  r_dim_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= INNER_RST;
            r_outer <= OUTER_RST;
            r_dim_x <= DIM_X_RST;
            r_dim_y <= DIM_Y_RST;
            r_dim_z <= DIM_Z_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INNER: r_inner <= i_cfg_data;
                REG_OUTER: r_outer <= i_cfg_data;
                REG_DIM_X: r_dim_x <= i_cfg_data[DIM_X_W-1:0];
                REG_DIM_Y: r_dim_y <= i_cfg_data[DIM_Y_W-1:0];
                REG_DIM_Z: r_dim_z <= i_cfg_data[DIM_Z_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped dimensions
    logic [DIM_X_W-1:0] w_ex;
    logic [DIM_Y_W-1:0] w_ey;
    logic [DIM_Z_W-1:0] w_ez;

    assign w_ex = (r_dim_x < DIM_X_W'(DIM_MIN)) ? DIM_X_W'(DIM_MIN) :
                  (r_dim_x > DIM_X_W'(MAX_PLANES)) ? DIM_X_W'(MAX_PLANES) : r_dim_x;
    assign w_ey = (r_dim_y < DIM_Y_W'(DIM_MIN)) ? DIM_Y_W'(DIM_MIN) :
                  (r_dim_y > DIM_Y_W'(MAX_ROWS)) ? DIM_Y_W'(MAX_ROWS) : r_dim_y;
    assign w_ez = (r_dim_z < DIM_Z_W'(DIM_MIN)) ? DIM_Z_W'(DIM_MIN) :
                  (r_dim_z > DIM_Z_W'(MAX_COLS)) ? DIM_Z_W'(MAX_COLS) : r_dim_z;

    // stage enables, valid bits
    logic              r_v  [1:NSTAGE];
    logic              w_en [1:NSTAGE+1];
    logic              w_accept;

    always_comb begin
        w_en[NSTAGE+1] = i_out_ready;
        for (int k = NSTAGE; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_in_ready = w_en[1];
    assign w_accept   = i_in_valid && w_en[1];

    // position, restarted when beyond the dimensions
    logic [PLANE_W-1:0] r_pos_p;
    logic [ROW_W-1:0]   r_pos_r;
    logic [COL_W-1:0]   r_pos_c;
    logic               w_wrap;
    logic [PLANE_W-1:0] w_p;
    logic [ROW_W-1:0]   w_r;
    logic [COL_W-1:0]   w_c;
    logic [PLANE_W:0]   w_p_inc;
    logic [ROW_W:0]     w_r_inc;
    logic [COL_W:0]     w_c_inc;
    logic [PLANE_W-1:0] n_pos_p;
    logic [ROW_W-1:0]   n_pos_r;
    logic [COL_W-1:0]   n_pos_c;

    assign w_wrap = ({1'b0, r_pos_p} >= w_ex) || ({1'b0, r_pos_r} >= w_ey) ||
                    ({1'b0, r_pos_c} >= w_ez);
    assign w_p = w_wrap ? '0 : r_pos_p;
    assign w_r = w_wrap ? '0 : r_pos_r;
    assign w_c = w_wrap ? '0 : r_pos_c;
    assign w_p_inc = {1'b0, w_p} + 1'b1;
    assign w_r_inc = {1'b0, w_r} + 1'b1;
    assign w_c_inc = {1'b0, w_c} + 1'b1;

    always_comb begin
        n_pos_p = w_p;
        n_pos_r = w_r;
        n_pos_c = w_c_inc[COL_W-1:0];
        if (w_c_inc == w_ez) begin
            n_pos_c = '0;
            n_pos_r = w_r_inc[ROW_W-1:0];
            if (w_r_inc == w_ey) begin
                n_pos_r = '0;
                n_pos_p = (w_p_inc == w_ex) ? '0 : w_p_inc[PLANE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_p <= '0;
            r_pos_r <= '0;
            r_pos_c <= '0;
        end else if (w_accept) begin
            r_pos_p <= n_pos_p;
            r_pos_r <= n_pos_r;
            r_pos_c <= n_pos_c;
        end
    end

    // per-item flags
    logic w_emit;
    logic w_ins;
    logic w_ok_pre;
    logic w_last;

    assign w_emit = (w_p != '0);
    assign w_ins  = (i_in_item.label > r_inner) && (i_in_item.label < r_outer);
    assign w_ok_pre = (w_p >= PLANE_W'(2)) && (w_r != '0) && (w_r_inc < w_ey) &&
                      (w_c != '0) && (w_c_inc < w_ez);
    assign w_last = ({1'b0, w_p} == w_ex - 1'b1) && ({1'b0, w_r} == w_ey - 1'b1) &&
                    ({1'b0, w_c} == w_ez - 1'b1);

    // plane memories: {inside flag, potential} at {plane parity, row, column}
    logic                w_slot;
    logic [ADDR_W-1:0]   w_a;
    logic [MEM_AW-1:0]   w_waddr;
    logic [MEM_DW-1:0]   w_wdata;
    logic [MEM_DW-1:0]   w_rd_xm;
    logic [MEM_DW-1:0]   w_rd_yp;
    logic [MEM_DW-1:0]   w_rd_ym;
    logic [MEM_DW-1:0]   w_rd_zp;
    logic [MEM_DW-1:0]   w_rd_zm;
    logic [MEM_DW-1:0]   w_rd_ctr;

    assign w_slot  = w_p[0];
    assign w_a     = {w_r, w_c};
    assign w_waddr = {w_slot, w_a};
    assign w_wdata = {w_ins, i_in_item.potential};

    mng_ram #(.AW(MEM_AW), .DW(MEM_DW)) u_ram_x (
        .i_clk     (i_clk),
        .i_we      (w_accept),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_en[1]),
        .i_raddr_a ({w_slot, w_a}),
        .i_raddr_b ({~w_slot, w_a + ADDR_W'(MAX_COLS)}),
        .o_rdata_a (w_rd_xm),
        .o_rdata_b (w_rd_yp)
    );

    mng_ram #(.AW(MEM_AW), .DW(MEM_DW)) u_ram_y (
        .i_clk     (i_clk),
        .i_we      (w_accept),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_en[1]),
        .i_raddr_a ({~w_slot, w_a - ADDR_W'(MAX_COLS)}),
        .i_raddr_b ({~w_slot, w_a + ADDR_W'(1)}),
        .o_rdata_a (w_rd_ym),
        .o_rdata_b (w_rd_zp)
    );

    mng_ram #(.AW(MEM_AW), .DW(MEM_DW)) u_ram_z (
        .i_clk     (i_clk),
        .i_we      (w_accept),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_en[1]),
        .i_raddr_a ({~w_slot, w_a - ADDR_W'(1)}),
        .i_raddr_b ({~w_slot, w_a}),
        .o_rdata_a (w_rd_zm),
        .o_rdata_b (w_rd_ctr)
    );

    // stage 1: item registers beside the memory reads
    logic signed [15:0] r1_pv;
    logic               r1_ok;
    logic               r1_last;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_pv   <= i_in_item.potential;
            r1_ok   <= w_ok_pre;
            r1_last <= w_last;
        end
    end

    // stage 2: central differences
    logic signed [16:0] r2_dx;
    logic signed [16:0] r2_dy;
    logic signed [16:0] r2_dz;
    logic               r2_ok;
    logic               r2_last;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_dx   <= {r1_pv[15], r1_pv} - {w_rd_xm[15], w_rd_xm[15:0]};
            r2_dy   <= {w_rd_yp[15], w_rd_yp[15:0]} - {w_rd_ym[15], w_rd_ym[15:0]};
            r2_dz   <= {w_rd_zp[15], w_rd_zp[15:0]} - {w_rd_zm[15], w_rd_zm[15:0]};
            r2_ok   <= r1_ok && w_rd_ctr[MEM_DW-1];
            r2_last <= r1_last;
        end
    end

    // stage 3: squares of magnitudes
    logic [16:0]     w_ax;
    logic [16:0]     w_ay;
    logic [16:0]     w_az;
    logic [SQ_W-1:0] r3_sq_x;
    logic [SQ_W-1:0] r3_sq_y;
    logic [SQ_W-1:0] r3_sq_z;
    logic            r3_neg_x;
    logic            r3_neg_y;
    logic            r3_neg_z;
    logic            r3_ok;
    logic            r3_last;

    assign w_ax = r2_dx[16] ? 17'(-r2_dx) : 17'(r2_dx);
    assign w_ay = r2_dy[16] ? 17'(-r2_dy) : 17'(r2_dy);
    assign w_az = r2_dz[16] ? 17'(-r2_dz) : 17'(r2_dz);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_sq_x  <= SQ_W'(w_ax[15:0]) * SQ_W'(w_ax[15:0]);
            r3_sq_y  <= SQ_W'(w_ay[15:0]) * SQ_W'(w_ay[15:0]);
            r3_sq_z  <= SQ_W'(w_az[15:0]) * SQ_W'(w_az[15:0]);
            r3_neg_x <= r2_dx[16];
            r3_neg_y <= r2_dy[16];
            r3_neg_z <= r2_dz[16];
            r3_ok    <= r2_ok;
            r3_last  <= r2_last;
        end
    end

    // stage 4: squared magnitude and zero test
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] r4_sum;
    logic [SQ_W-1:0]  r4_sq_x;
    logic [SQ_W-1:0]  r4_sq_y;
    logic [SQ_W-1:0]  r4_sq_z;
    t_side            r4_side;

    assign w_sum = SUM_W'(r3_sq_x) + SUM_W'(r3_sq_y) + SUM_W'(r3_sq_z);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_sum        <= w_sum;
            r4_sq_x       <= r3_sq_x;
            r4_sq_y       <= r3_sq_y;
            r4_sq_z       <= r3_sq_z;
            r4_side.ok    <= r3_ok;
            r4_side.zero  <= !r3_ok || (w_sum == '0);
            r4_side.last  <= r3_last;
            r4_side.neg_x <= r3_neg_x;
            r4_side.neg_y <= r3_neg_y;
            r4_side.neg_z <= r3_neg_z;
        end
    end

    // magnitude search, one quotient bit per stage
    logic [QBITS-1:0] w_div_en;
    logic [QBITS-1:0] w_q_x;
    logic [QBITS-1:0] w_q_y;
    logic [QBITS-1:0] w_q_z;
    t_side            r_sd [QBITS];

    always_comb begin
        for (int k = 0; k < QBITS; k++) begin
            w_div_en[k] = w_en[DIV_FIRST + QBITS - 1 - k];
        end
    end

    mng_udiv u_div_x (
        .i_clk (i_clk), .i_en (w_div_en), .i_sq (r4_sq_x), .i_sum (r4_sum), .o_q (w_q_x)
    );
    mng_udiv u_div_y (
        .i_clk (i_clk), .i_en (w_div_en), .i_sq (r4_sq_y), .i_sum (r4_sum), .o_q (w_q_y)
    );
    mng_udiv u_div_z (
        .i_clk (i_clk), .i_en (w_div_en), .i_sq (r4_sq_z), .i_sum (r4_sum), .o_q (w_q_z)
    );

    // side flags travel with the search stages
    always_ff @(posedge i_clk) begin
        if (w_div_en[QBITS-1]) begin
            r_sd[QBITS-1] <= r4_side;
        end
        for (int k = 0; k < QBITS - 1; k++) begin
            if (w_div_en[k]) begin
                r_sd[k] <= r_sd[k+1];
            end
        end
    end

    // output stage: sign and mask
    logic [15:0] w_mx;
    logic [15:0] w_my;
    logic [15:0] w_mz;
    t_res        r_out;

    assign w_mx = {1'b0, w_q_x};
    assign w_my = {1'b0, w_q_y};
    assign w_mz = {1'b0, w_q_z};

    always_ff @(posedge i_clk) begin
        if (w_en[NSTAGE]) begin
            r_out.norm_x     <= r_sd[0].zero ? '0 : (r_sd[0].neg_x ? 16'(-w_mx) : w_mx);
            r_out.norm_y     <= r_sd[0].zero ? '0 : (r_sd[0].neg_y ? 16'(-w_my) : w_my);
            r_out.norm_z     <= r_sd[0].zero ? '0 : (r_sd[0].neg_z ? 16'(-w_mz) : w_mz);
            r_out.inside_res <= r_sd[0].ok;
            r_out.last       <= r_sd[0].last;
        end
    end

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NSTAGE; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (w_en[1]) begin
                r_v[1] <= w_accept && w_emit;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_out_valid = r_v[NSTAGE];
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ rtl/mng_checker.sv @@
// port-level checks for the masked gradient block, bound to the top level
// uses mng_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "masked_normalized_gradient_3d_top_assert.svh"

module mng_checker import mng_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_res o_out_item
);

    // a stalled result stays
    `MNG_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")
    `MNG_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_item), "result moved")

    // empty output stage means the whole pipeline can move
    `MNG_ASSERT_IMP(a_ready_empty, !o_out_valid, o_in_ready, "not ready with output empty")

    // masked voxels give a zero vector
    `MNG_ASSERT_IMP(a_masked_zero, o_out_valid && !o_out_item.inside_res, (o_out_item.norm_x == '0) && (o_out_item.norm_y == '0) && (o_out_item.norm_z == '0), "masked voxel not zero")

    // components stay within plus or minus full scale
    `MNG_ASSERT_IMP(a_range, o_out_valid, (o_out_item.norm_x != 16'sh8000) && (o_out_item.norm_y != 16'sh8000) && (o_out_item.norm_z != 16'sh8000), "component out of range")

endmodule

bind masked_normalized_gradient_3d_top mng_checker u_mng_checker (.*);

`default_nettype wire
